// ===== rtl/abs_slip_pd_brake_regulator_core_defines.svh =====
// Assertion macros shared by the regulator RTL.
// Every macro expects clk and rst_n in scope.
`ifndef ABS_SLIP_PD_BRAKE_REGULATOR_CORE_DEFINES_SVH
`define ABS_SLIP_PD_BRAKE_REGULATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ABSPD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ABSPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/abspd_pkg.sv =====
`default_nettype none

package abspd_pkg;

    localparam int SPD_W   = 32;
    localparam int TQ_W    = 32;
    localparam int SLIP_W  = 16;
    localparam int PCT_W   = 15;
    localparam int MODE_W  = 2;
    localparam int GAIN_W  = 24;
    localparam int STOP_W  = 16;
    localparam int LVS_W   = 20;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Serial step counts: one gain bit per multiply step, one quotient bit per divide step.
    localparam int MUL_STEPS = GAIN_W;
    localparam int DIV_STEPS = PCT_W;
    localparam int CNT_W     = 5;

    localparam logic [MODE_W-1:0] MODE_STOP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOW  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REG  = 2'd2;

    localparam logic [PCT_W-1:0] PCT_FULL = 15'd25600;

    localparam logic [1:0] REG_PROP  = 2'd0;
    localparam logic [1:0] REG_DERIV = 2'd1;
    localparam logic [1:0] REG_STOP  = 2'd2;
    localparam logic [1:0] REG_LVS   = 2'd3;

    localparam logic [GAIN_W-1:0] PROP_RESET  = 24'd0;
    localparam logic [GAIN_W-1:0] DERIV_RESET = 24'd0;
    localparam logic [STOP_W-1:0] STOP_RESET  = 16'd66;
    localparam logic [LVS_W-1:0]  LVS_RESET   = 20'd6554;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_TORQ,
        S_RED,
        S_SCALE,
        S_DIV,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/abspd_in_if.sv =====
`default_nettype none

interface abspd_in_if;
    import abspd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [SPD_W-1:0]  wheel_speed;
    logic signed [TQ_W-1:0]   requested_torque;
    logic signed [SLIP_W-1:0] slip_setpoint;
    logic signed [SLIP_W-1:0] measured_slip;
    logic signed [SPD_W-1:0]  vehicle_speed;

    modport source (
        output valid, wheel_speed, requested_torque, slip_setpoint, measured_slip,
               vehicle_speed,
        input  ready
    );

    modport sink (
        input  valid, wheel_speed, requested_torque, slip_setpoint, measured_slip,
               vehicle_speed,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/abspd_out_if.sv =====
`default_nettype none

interface abspd_out_if;
    import abspd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [TQ_W-1:0]  brake_torque;
    logic [PCT_W-1:0]        interference_percent;
    logic [MODE_W-1:0]       mode;

    modport source (
        output valid, brake_torque, interference_percent, mode,
        input  ready
    );

    modport sink (
        input  valid, brake_torque, interference_percent, mode,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/abs_slip_pd_brake_regulator_core.sv =====
// ABS wheel-slip PD brake regulator, one control tick per input beat.
// in_ch carries one wheel tick (wheel speed, requested torque, slip setpoint,
// measured slip, vehicle speed); out_ch returns one beat per tick with the
// brake torque, the interference percent and the mode. Both are valid/ready.
// Gains and thresholds sit in four APB registers at byte addresses 0, 4, 8, 12;
// write them only while the block is idle. pready is tied high.
// A stopped-wheel or low-speed tick goes from evaluation straight to the
// final step. A regulated tick runs the bit-serial PD multiplier (one gain
// bit per cycle), then the torque sum, clamp and scaling, then the restoring
// divider for the percent (one quotient bit per cycle). A regulated tick
// with no torque reduction skips the scaling and the divider.
// One tick is in work at a time, so the next tick can be taken in the cycle
// after the previous result is loaded.
// The output register parts the two sides: a new tick is accepted while a
// finished result still waits; when the receiver stalls, the next result
// holds in its final step until the output register frees up.
// Reset (rst_n low, asynchronous) restores the register defaults, clears the
// remembered slip and drops any beat in flight.
`default_nettype none
`include "abs_slip_pd_brake_regulator_core_defines.svh"

module abs_slip_pd_brake_regulator_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    abspd_in_if.sink                          in_ch,
    abspd_out_if.source                       out_ch,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [abspd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [abspd_pkg::PDATA_W-1:0] pwdata,
    output logic      [abspd_pkg::PDATA_W-1:0] prdata,
    output logic                              pready
);
    import abspd_pkg::*;

    // Control state
    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic ov_reg, ov_next;
    logic signed [SLIP_W-1:0] last_slip_reg, last_slip_next;

    // Configuration registers
    logic [GAIN_W-1:0] prop_reg;
    logic [GAIN_W-1:0] deriv_reg;
    logic [STOP_W-1:0] stop_reg;
    logic [LVS_W-1:0]  lvs_reg;

    // Latched tick
    logic signed [SPD_W-1:0]  ws_reg, ws_next;
    logic signed [TQ_W-1:0]   rt_reg, rt_next;
    logic signed [SLIP_W-1:0] sp_reg, sp_next;
    logic signed [SLIP_W-1:0] sl_reg, sl_next;
    logic signed [SPD_W-1:0]  vs_reg, vs_next;

    // Datapath
    logic signed [TQ_W:0]     base_reg, base_next;
    logic signed [SLIP_W:0]   e1_reg, e1_next;
    logic signed [SLIP_W:0]   e2_reg, e2_next;
    logic [GAIN_W-1:0]        pg_sh_reg, pg_sh_next;
    logic [GAIN_W-1:0]        dg_sh_reg, dg_sh_next;
    logic signed [SLIP_W+2:0] ps_reg, ps_next;
    logic [GAIN_W-1:0]        low_sh_reg, low_sh_next;
    logic signed [TQ_W-1:0]   tq_reg, tq_next;
    logic [TQ_W-1:0]          div_reg, div_next;
    logic [TQ_W-1:0]          red_reg, red_next;
    logic [TQ_W-1:0]          rem_reg, rem_next;
    logic [PCT_W-1:0]         num_sh_reg, num_sh_next;
    logic [PCT_W-1:0]         q_reg, q_next;
    logic [MODE_W-1:0]        mode_reg, mode_next;

    // Output register
    logic signed [TQ_W-1:0] otq_reg, otq_next;
    logic [PCT_W-1:0]       opct_reg, opct_next;
    logic [MODE_W-1:0]      omode_reg, omode_next;

    // Combinational helpers
    logic [SPD_W-1:0]         ws_mag;
    logic [TQ_W-1:0]          rt_mag;
    logic signed [TQ_W:0]     base_val;
    logic                     is_stopped;
    logic                     is_low;
    logic signed [TQ_W-1:0]   base_sat;
    logic signed [SLIP_W+1:0] step_term;
    logic signed [SLIP_W+3:0] step_sum;
    logic signed [TQ_W+1:0]   tsum;
    logic                     ws_pos;
    logic                     clamp_zero;
    logic [TQ_W-1:0]          tq_mag;
    logic signed [TQ_W:0]     red_val;
    logic [TQ_W+4:0]          red_x25;
    logic [TQ_W:0]            rem_shift;
    logic                     rem_ge;
    logic                     in_accept;
    logic                     cfg_write;

    assign in_accept = in_ch.valid && in_ch.ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    assign in_ch.ready                 = (state_reg == S_IDLE);
    assign out_ch.valid                = ov_reg;
    assign out_ch.brake_torque         = otq_reg;
    assign out_ch.interference_percent = opct_reg;
    assign out_ch.mode                 = omode_reg;

    // Classification of the latched tick
    assign ws_mag     = ws_reg[SPD_W-1] ? SPD_W'(-ws_reg) : SPD_W'(ws_reg);
    assign rt_mag     = rt_reg[TQ_W-1] ? TQ_W'(-rt_reg) : TQ_W'(rt_reg);
    assign is_stopped = ws_mag < {{(SPD_W-STOP_W){1'b0}}, stop_reg};
    assign is_low     = $signed({vs_reg[SPD_W-1], vs_reg})
                        < $signed({{(SPD_W+1-LVS_W){1'b0}}, lvs_reg});
    // Base torque opposes the spin; a forward or still wheel gets negative torque
    assign base_val   = ws_reg[SPD_W-1] ? $signed({1'b0, rt_mag}) : -$signed({1'b0, rt_mag});
    // Only +2^31 can overflow 32 bits
    assign base_sat   = (!base_val[TQ_W] && base_val[TQ_W-1]) ? {1'b0, {(TQ_W-1){1'b1}}}
                                                               : base_val[TQ_W-1:0];

    // One multiply step: add the selected error terms, shift one product bit out
    assign step_term = (pg_sh_reg[0] ? {e1_reg[SLIP_W], e1_reg} : '0)
                     + (dg_sh_reg[0] ? {e2_reg[SLIP_W], e2_reg} : '0);
    assign step_sum  = {ps_reg[SLIP_W+2], ps_reg}
                     + {{2{step_term[SLIP_W+1]}}, step_term};

    // Torque = base + floor(product / 2^14)
    assign tsum = {base_reg[TQ_W], base_reg}
                + (TQ_W+2)'($signed({ps_reg, low_sh_reg[GAIN_W-1:14]}));
    assign ws_pos     = !ws_reg[SPD_W-1] && (ws_reg != '0);
    assign clamp_zero = (ws_pos && !tsum[TQ_W+1] && (tsum != '0))
                     || (ws_reg[SPD_W-1] && tsum[TQ_W+1]);

    // Reduction and its scaling by 25 (the 2^10 part goes into the divider shift)
    assign tq_mag  = tq_reg[TQ_W-1] ? TQ_W'(-tq_reg) : TQ_W'(tq_reg);
    assign red_val = $signed({1'b0, div_reg}) - $signed({1'b0, tq_mag});
    assign red_x25 = ({5'b0, red_reg} << 4) + ({5'b0, red_reg} << 3) + {5'b0, red_reg};

    // One restoring divide step
    assign rem_shift = {rem_reg, num_sh_reg[PCT_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, div_reg};

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ov_next        = ov_reg && !out_ch.ready;
        last_slip_next = last_slip_reg;
        ws_next        = ws_reg;
        rt_next        = rt_reg;
        sp_next        = sp_reg;
        sl_next        = sl_reg;
        vs_next        = vs_reg;
        base_next      = base_reg;
        e1_next        = e1_reg;
        e2_next        = e2_reg;
        pg_sh_next     = pg_sh_reg;
        dg_sh_next     = dg_sh_reg;
        ps_next        = ps_reg;
        low_sh_next    = low_sh_reg;
        tq_next        = tq_reg;
        div_next       = div_reg;
        red_next       = red_reg;
        rem_next       = rem_reg;
        num_sh_next    = num_sh_reg;
        q_next         = q_reg;
        mode_next      = mode_reg;
        otq_next       = otq_reg;
        opct_next      = opct_reg;
        omode_next     = omode_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    ws_next    = in_ch.wheel_speed;
                    rt_next    = in_ch.requested_torque;
                    sp_next    = in_ch.slip_setpoint;
                    sl_next    = in_ch.measured_slip;
                    vs_next    = in_ch.vehicle_speed;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                q_next = '0;
                if (is_stopped)
                begin
                    tq_next    = '0;
                    mode_next  = MODE_STOP;
                    state_next = S_DONE;
                end
                else if (is_low)
                begin
                    tq_next    = base_sat;
                    mode_next  = MODE_LOW;
                    state_next = S_DONE;
                end
                else
                begin
                    // Derivative term enters negated: last_slip - slip
                    base_next   = base_val;
                    e1_next     = {sp_reg[SLIP_W-1], sp_reg} - {sl_reg[SLIP_W-1], sl_reg};
                    e2_next     = {last_slip_reg[SLIP_W-1], last_slip_reg}
                                - {sl_reg[SLIP_W-1], sl_reg};
                    pg_sh_next  = prop_reg;
                    dg_sh_next  = deriv_reg;
                    ps_next     = '0;
                    low_sh_next = '0;
                    cnt_next    = '0;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                ps_next     = step_sum[SLIP_W+3:1];
                low_sh_next = {step_sum[0], low_sh_reg[GAIN_W-1:1]};
                pg_sh_next  = pg_sh_reg >> 1;
                dg_sh_next  = dg_sh_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                begin
                    state_next = S_TORQ;
                end
            end
            S_TORQ:
            begin
                // Clamp against spin, then saturate to 32 bits
                if (clamp_zero)
                begin
                    tq_next = '0;
                end
                else if (!tsum[TQ_W+1] && (tsum[TQ_W:TQ_W-1] != 2'b00))
                begin
                    tq_next = {1'b0, {(TQ_W-1){1'b1}}};
                end
                else if (tsum[TQ_W+1] && (tsum[TQ_W:TQ_W-1] != 2'b11))
                begin
                    tq_next = {1'b1, {(TQ_W-1){1'b0}}};
                end
                else
                begin
                    tq_next = tsum[TQ_W-1:0];
                end
                div_next       = base_reg[TQ_W] ? TQ_W'(-base_reg) : base_reg[TQ_W-1:0];
                last_slip_next = sl_reg;
                mode_next      = MODE_REG;
                state_next     = S_RED;
            end
            S_RED:
            begin
                // A positive reduction implies a nonzero base magnitude
                if (!red_val[TQ_W] && (red_val != '0))
                begin
                    red_next   = red_val[TQ_W-1:0];
                    state_next = S_SCALE;
                end
                else
                begin
                    q_next     = '0;
                    state_next = S_DONE;
                end
            end
            S_SCALE:
            begin
                // Numerator red*25*2^10; its top part already lies below the divisor
                rem_next    = red_x25[TQ_W+4:5];
                num_sh_next = {red_x25[4:0], 10'b0};
                q_next      = '0;
                cnt_next    = '0;
                state_next  = S_DIV;
            end
            S_DIV:
            begin
                rem_next    = rem_ge ? TQ_W'(rem_shift - {1'b0, div_reg}) : rem_shift[TQ_W-1:0];
                num_sh_next = num_sh_reg << 1;
                q_next      = {q_reg[PCT_W-2:0], rem_ge};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hold here while the output register still waits on the receiver
                if (!ov_reg || out_ch.ready)
                begin
                    otq_next   = tq_reg;
                    opct_next  = q_reg;
                    omode_next = mode_reg;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ov_reg        <= 1'b0;
            last_slip_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ov_reg        <= ov_next;
            last_slip_reg <= last_slip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ws_reg     <= ws_next;
        rt_reg     <= rt_next;
        sp_reg     <= sp_next;
        sl_reg     <= sl_next;
        vs_reg     <= vs_next;
        base_reg   <= base_next;
        e1_reg     <= e1_next;
        e2_reg     <= e2_next;
        pg_sh_reg  <= pg_sh_next;
        dg_sh_reg  <= dg_sh_next;
        ps_reg     <= ps_next;
        low_sh_reg <= low_sh_next;
        tq_reg     <= tq_next;
        div_reg    <= div_next;
        red_reg    <= red_next;
        rem_reg    <= rem_next;
        num_sh_reg <= num_sh_next;
        q_reg      <= q_next;
        mode_reg   <= mode_next;
        otq_reg    <= otq_next;
        opct_reg   <= opct_next;
        omode_reg  <= omode_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_reg  <= PROP_RESET;
            deriv_reg <= DERIV_RESET;
            stop_reg  <= STOP_RESET;
            lvs_reg   <= LVS_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_PROP:  prop_reg  <= pwdata[GAIN_W-1:0];
                REG_DERIV: deriv_reg <= pwdata[GAIN_W-1:0];
                REG_STOP:  stop_reg  <= pwdata[STOP_W-1:0];
                REG_LVS:   lvs_reg   <= pwdata[LVS_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_PROP:  prdata = {{(PDATA_W-GAIN_W){1'b0}}, prop_reg};
            REG_DERIV: prdata = {{(PDATA_W-GAIN_W){1'b0}}, deriv_reg};
            REG_STOP:  prdata = {{(PDATA_W-STOP_W){1'b0}}, stop_reg};
            REG_LVS:   prdata = {{(PDATA_W-LVS_W){1'b0}}, lvs_reg};
            default:   prdata = '0;
        endcase
    end

    `ABSPD_ASSERT_NEXT(a_accept_to_eval, in_accept, state_reg == S_EVAL,
        "accepted beat did not advance to evaluation")
    `ABSPD_ASSERT_SAME(a_out_load_from_done, out_ch.valid && !$past(out_ch.valid),
        $past(state_reg) == S_DONE, "output loaded outside the final step")
    `ABSPD_ASSERT_SAME(a_div_rem_below, state_reg == S_DIV, rem_reg < div_reg,
        "divider remainder not below divisor")
    `ABSPD_ASSERT_SAME(a_pct_only_regulated, out_ch.valid && (out_ch.mode != MODE_REG),
        out_ch.interference_percent == '0, "nonzero percent outside regulated mode")
    `ABSPD_ASSERT_SAME(a_pct_range, out_ch.valid, out_ch.interference_percent <= PCT_FULL,
        "percent above full scale")

endmodule

`default_nettype wire

// ===== tb/abs_slip_pd_brake_regulator_core_tb.sv =====
`default_nettype none

module abs_slip_pd_brake_regulator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import abspd_pkg::*;

    // Torque saturation bounds (Q24.8 in 32 bits) and register masks.
    localparam longint TORQ_HI = 64'sd2147483647;
    localparam longint TORQ_LO = -64'sd2147483648;
    localparam logic [31:0] GAIN_MASK = 32'((64'd1 << GAIN_W) - 1);
    localparam logic [31:0] STOP_MASK = 32'((64'd1 << STOP_W) - 1);
    localparam logic [31:0] LVS_MASK  = 32'((64'd1 << LVS_W) - 1);

    // Padding that outlasts a regulated tick from its accept to its result.
    localparam int SETTLE_PAD      = 60;
    localparam int PHASES          = 8;
    localparam int TICKS_PER_PHASE = 112;
    localparam int SQUEEZE_CYCLES  = 300;
    localparam longint TIMEOUT_NS  = 5_000_000;

    typedef struct {
        logic signed [SPD_W-1:0]  wheel_speed;
        logic signed [TQ_W-1:0]   requested_torque;
        logic signed [SLIP_W-1:0] slip_setpoint;
        logic signed [SLIP_W-1:0] measured_slip;
        logic signed [SPD_W-1:0]  vehicle_speed;
    } wheel_tick_t;

    typedef struct {
        logic signed [TQ_W-1:0] brake_torque;
        logic [PCT_W-1:0]       interference_percent;
        logic [MODE_W-1:0]      mode;
    } brake_cmd_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_e;

    // Shadow of the regulator: own copy of the registers and the remembered
    // slip, plus the queue of brake commands still owed by the block.
    class brake_scoreboard;
        logic [GAIN_W-1:0] prop_gain  = PROP_RESET;
        logic [GAIN_W-1:0] deriv_gain = DERIV_RESET;
        logic [STOP_W-1:0] stop_limit = STOP_RESET;
        logic [LVS_W-1:0]  lvs_limit  = LVS_RESET;
        longint            prev_slip  = 0;
        brake_cmd_t        due_cmds[$];
        int                errors     = 0;
        int                checked    = 0;
        int                mode_hits[3];

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_PROP:  prop_gain  = value[GAIN_W-1:0];
                REG_DERIV: deriv_gain = value[GAIN_W-1:0];
                REG_STOP:  stop_limit = value[STOP_W-1:0];
                REG_LVS:   lvs_limit  = value[LVS_W-1:0];
                default: ;
            endcase
        endfunction

        function longint mag(longint x);
            return (x < 0) ? -x : x;
        endfunction

        function longint sat_torque(longint x);
            if (x > TORQ_HI) return TORQ_HI;
            if (x < TORQ_LO) return TORQ_LO;
            return x;
        endfunction

        function brake_cmd_t predict_cmd(wheel_tick_t t);
            longint ws, rt, sp, sl, vs;
            longint base, acc, torque, abase, reduction;
            brake_cmd_t c;
            ws = longint'(t.wheel_speed);
            rt = longint'(t.requested_torque);
            sp = longint'(t.slip_setpoint);
            sl = longint'(t.measured_slip);
            vs = longint'(t.vehicle_speed);
            c.brake_torque = '0;
            c.interference_percent = '0;
            if (mag(ws) < longint'(stop_limit)) begin
                c.mode = MODE_STOP;
                return c;
            end
            base = (ws >= 0) ? -mag(rt) : mag(rt);
            if (vs < longint'(lvs_limit)) begin
                c.brake_torque = TQ_W'(sat_torque(base));
                c.mode = MODE_LOW;
                return c;
            end
            acc = base * 16384
                + longint'(prop_gain) * (sp - sl)
                - longint'(deriv_gain) * (sl - prev_slip);
            torque = acc >>> 14;
            if ((ws > 0 && torque > 0) || (ws < 0 && torque < 0))
                torque = 0;
            torque = sat_torque(torque);
            abase = mag(base);
            reduction = abase - mag(torque);
            if (reduction > 0 && abase > 0)
                c.interference_percent = PCT_W'((reduction * longint'(PCT_FULL)) / abase);
            prev_slip = sl;
            c.brake_torque = TQ_W'(torque);
            c.mode = MODE_REG;
            return c;
        endfunction

        function void note_tick(wheel_tick_t t);
            brake_cmd_t c;
            c = predict_cmd(t);
            mode_hits[c.mode]++;
            due_cmds.push_back(c);
        endfunction

        function void check_cmd(brake_cmd_t got);
            brake_cmd_t want;
            if (due_cmds.size() == 0) begin
                $display("%0t: unexpected result beat torque %0d percent %0d mode %0d",
                         $time, got.brake_torque, got.interference_percent, got.mode);
                errors++;
                return;
            end
            want = due_cmds.pop_front();
            checked++;
            if (got.brake_torque !== want.brake_torque) begin
                $display("%0t: brake_torque expected %0d, got %0d",
                         $time, want.brake_torque, got.brake_torque);
                errors++;
            end
            if (got.interference_percent !== want.interference_percent) begin
                $display("%0t: interference_percent expected %0d, got %0d",
                         $time, want.interference_percent, got.interference_percent);
                errors++;
            end
            if (got.mode !== want.mode) begin
                $display("%0t: mode expected %0d, got %0d", $time, want.mode, got.mode);
                errors++;
            end
        endfunction

        function int due_count();
            return due_cmds.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    abspd_in_if  in_ch ();
    abspd_out_if out_ch ();

    abs_slip_pd_brake_regulator_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    brake_scoreboard board = new();

    // Sender pacing and the handshake between sender and receiver for the
    // long hold-off.
    int burst_left  = 0;
    int gap_max     = 12;
    bit squeeze_req = 1'b0;
    int squeezes    = 0;
    int reg_writes  = 0;
    int settings    = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Give up if the run hangs anywhere.
    initial
    begin
        #(TIMEOUT_NS);
        $display("[abs_slip_pd_brake_regulator_core] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------

    // Run one setup + access pair; leave psel high so a back-to-back access
    // does not toggle it within one step. Capture prdata at the access edge.
    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
    endtask

    // Write a register, read it straight back, and mirror it in the shadow.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] rd;
        case (idx)
            REG_PROP, REG_DERIV: mask = GAIN_MASK;
            REG_STOP:            mask = STOP_MASK;
            default:             mask = LVS_MASK;
        endcase
        apb_access(1'b1, idx, value & mask, rd);
        apb_access(1'b0, idx, '0, rd);
        board.set_reg(idx, value & mask);
        reg_writes++;
        if ((rd & mask) !== (value & mask)) begin
            $display("%0t: register %0d readback expected %0h, got %0h",
                     $time, idx, value & mask, rd & mask);
            board.errors++;
        end
    endtask

    // Write all four registers back to back, then release the bus.
    task automatic apply_setting(input logic [31:0] prop, input logic [31:0] deriv,
                                 input logic [31:0] stop, input logic [31:0] lvs);
        write_reg(REG_PROP, prop);
        write_reg(REG_DERIV, deriv);
        write_reg(REG_STOP, stop);
        write_reg(REG_LVS, lvs);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings++;
    endtask

    // Pick a register value: zero, all ones, anything, or a small one.
    function automatic logic [31:0] pick_reg_value(input logic [31:0] mask);
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return mask;
            2:       return $urandom & mask;
            default: return $urandom_range(0, 20000) & mask;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one tick and hold it until the block takes the beat. Open a new
    // burst with a random gap once the current one is used up.
    task automatic offer_tick(input wheel_tick_t t);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_ch.valid            <= 1'b1;
        in_ch.wheel_speed      <= t.wheel_speed;
        in_ch.requested_torque <= t.requested_torque;
        in_ch.slip_setpoint    <= t.slip_setpoint;
        in_ch.measured_slip    <= t.measured_slip;
        in_ch.vehicle_speed    <= t.vehicle_speed;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        board.note_tick(t);
    endtask

    // Drop valid and wait for the block to go quiet: every owed result in,
    // then enough cycles for any tick still in the pipe.
    task automatic settle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (board.due_count() != 0) @(posedge clk);
        repeat (SETTLE_PAD) @(posedge clk);
    endtask

    function automatic wheel_tick_t mk_tick(input logic [31:0] ws, input logic [31:0] rt,
                                            input logic [15:0] sp, input logic [15:0] sl,
                                            input logic [31:0] vs);
        wheel_tick_t t;
        t.wheel_speed      = ws;
        t.requested_torque = rt;
        t.slip_setpoint    = sp;
        t.measured_slip    = sl;
        t.vehicle_speed    = vs;
        return t;
    endfunction

    // A 32-bit field value: full random, shifted down, an extreme, or small.
    function automatic logic [31:0] wide_value();
        logic [31:0] v;
        case ($urandom_range(0, 4))
            0, 1: v = $urandom;
            2:
            begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            3:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7fff_ffff;
                    2:       v = 32'h0000_0000;
                    3:       v = 32'hffff_ffff;
                    default: v = 32'h0000_0001;
                endcase
            end
            default:
            begin
                v = $urandom_range(0, 1 << 20);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
        endcase
        return v;
    endfunction

    // Mostly regulated ticks with random content; some stopped wheels, some
    // low-speed bypasses, and some pure noise.
    function automatic wheel_tick_t rand_tick();
        wheel_tick_t t;
        int unsigned kind;
        longint      lim_ws;
        longint      lim_vs;
        longint      w;
        t.wheel_speed      = wide_value();
        t.requested_torque = wide_value();
        t.slip_setpoint    = 16'($urandom);
        t.measured_slip    = 16'($urandom);
        t.vehicle_speed    = wide_value();
        lim_ws = longint'(board.stop_limit);
        lim_vs = longint'(board.lvs_limit);
        kind = $urandom_range(0, 99);
        if (kind < 10)
            return t;
        // keep measured slip close to the setpoint most of the time
        if ($urandom_range(0, 2) != 0)
            t.measured_slip = t.slip_setpoint + 16'($urandom_range(0, 600) - 300);
        if (kind < 20 && lim_ws > 0) begin
            w = longint'($urandom_range(0, 32'(lim_ws - 1)));
            t.wheel_speed = 32'(($urandom_range(0, 1) == 1) ? -w : w);
            return t;
        end
        w = longint'(t.wheel_speed);
        if ($urandom_range(0, 3) == 0 || (w < lim_ws && w > -lim_ws)) begin
            w = lim_ws + $urandom_range(0, 2000);
            t.wheel_speed = 32'(($urandom_range(0, 1) == 1) ? -w : w);
        end
        if (kind < 30) begin
            if (lim_vs > 0 && $urandom_range(0, 1) == 1)
                t.vehicle_speed = $urandom_range(0, 32'(lim_vs - 1));
            else
                t.vehicle_speed = {1'b1, 31'($urandom)};
        end else if ($urandom_range(0, 15) == 0) begin
            t.vehicle_speed = 32'(lim_vs);
        end else begin
            t.vehicle_speed = $urandom_range(32'h7fff_ffff, 32'(lim_vs));
        end
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Output side: check every beat, stall on a changing pattern, and hold
    // off for a long stretch when the sender asks for a squeeze.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        rx_pattern_e rx_pattern;
        int          pattern_left;
        int          hold_left;
        int          beat_ctr;
        logic        rdy;
        brake_cmd_t  got;
        rx_pattern   = RX_OPEN;
        pattern_left = 0;
        hold_left    = 0;
        beat_ctr     = 0;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got.brake_torque         = out_ch.brake_torque;
                got.interference_percent = out_ch.interference_percent;
                got.mode                 = out_ch.mode;
                board.check_cmd(got);
            end
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                hold_left   = SQUEEZE_CYCLES;
                squeezes++;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    rx_pattern   = rx_pattern_e'($urandom_range(0, 3));
                    pattern_left = $urandom_range(20, 200);
                    beat_ctr     = 0;
                end
                pattern_left--;
                case (rx_pattern)
                    RX_OPEN:   rdy = 1'b1;
                    RX_COIN:   rdy = 1'($urandom_range(0, 1));
                    RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        rdy = (beat_ctr % 3) != 0;
                        beat_ctr++;
                    end
                endcase
            end
            out_ch.ready <= rdy;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : driver
        logic [31:0] prop, deriv, stop, lvs;
        // drive every input to a known value from time zero
        rst_n                  <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        in_ch.valid            <= 1'b0;
        in_ch.wheel_speed      <= '0;
        in_ch.requested_torque <= '0;
        in_ch.slip_setpoint    <= '0;
        in_ch.measured_slip    <= '0;
        in_ch.vehicle_speed    <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks under the reset register values (gains zero).
        // Wheel stopped at zero and just inside the limit on both sides.
        offer_tick(mk_tick(32'd0, 32'd100, 16'd0, 16'd0, 32'h7fff_ffff));
        offer_tick(mk_tick(32'd65, -32'sd100, 16'd0, 16'd0, 32'h7fff_ffff));
        offer_tick(mk_tick(-32'sd65, 32'd100, 16'd0, 16'd0, 32'h7fff_ffff));
        // Low-speed bypass right at the edge, then with the most negative
        // torque on a backward wheel so the base saturates.
        offer_tick(mk_tick(32'd66, -32'sd5000, 16'd0, 16'd0, 32'd6553));
        offer_tick(mk_tick(-32'sd66, 32'h8000_0000, 16'd0, 16'd0, 32'h8000_0000));
        // Regulated with zero gains: torque is the base, saturated to 32 bits.
        offer_tick(mk_tick(32'd66, 32'h8000_0000, 16'd100, 16'd200, 32'd6554));
        offer_tick(mk_tick(32'h8000_0000, 32'h8000_0000, 16'd0, 16'd0, 32'h7fff_ffff));
        settle();

        // Full gains: spin clamp, saturation both ways, zero base.
        apply_setting(GAIN_MASK, GAIN_MASK, 32'(STOP_RESET), 32'(LVS_RESET));
        offer_tick(mk_tick(32'd1000, 32'd1000, 16'h7fff, 16'h8000, 32'h7fff_ffff));
        offer_tick(mk_tick(-32'sd1000, 32'd1000, 16'h8000, 16'h7fff, 32'h7fff_ffff));
        offer_tick(mk_tick(32'd1000, 32'h7fff_ffff, 16'd100, 16'd0, 32'h7fff_ffff));
        offer_tick(mk_tick(32'd1000, 32'h8000_0000, 16'h8000, 16'h7fff, 32'h7fff_ffff));
        offer_tick(mk_tick(32'h8000_0000, 32'h8000_0000, 16'h7fff, 16'h8000,
                           32'h7fff_ffff));
        offer_tick(mk_tick(32'd5000, 32'd0, -16'sd100, 16'd0, 32'h7fff_ffff));
        // Slip memory: a bypassed tick in between must not move it.
        offer_tick(mk_tick(32'd5000, 32'd1000, 16'd0, 16'd50, 32'h7fff_ffff));
        offer_tick(mk_tick(32'd5000, 32'd1000, 16'd0, -16'sd20000, 32'd0));
        offer_tick(mk_tick(32'd5000, 32'd1000, 16'd0, 16'd60, 32'h7fff_ffff));
        // Fastest wheel at exactly the low-speed threshold, then a tiny one.
        offer_tick(mk_tick(32'h7fff_ffff, 32'h7fff_ffff, 16'h7fff, 16'h7fff, 32'd6554));
        offer_tick(mk_tick(32'hffff_ffff, 32'h7fff_ffff, 16'd0, 16'd0, 32'h7fff_ffff));

        // Random phases, each under its own register setting. The first two
        // hit the extremes; the rest draw from zero / max / random / small.
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            if (ph == 0) begin
                prop = GAIN_MASK; deriv = GAIN_MASK; stop = '0; lvs = '0;
            end else if (ph == 1) begin
                prop = '0; deriv = '0; stop = STOP_MASK; lvs = LVS_MASK;
            end else begin
                prop  = pick_reg_value(GAIN_MASK);
                deriv = pick_reg_value(GAIN_MASK);
                stop  = pick_reg_value(STOP_MASK);
                lvs   = pick_reg_value(LVS_MASK);
            end
            apply_setting(prop, deriv, stop, lvs);
            // every third phase runs the sender flat out
            gap_max = (ph % 3 == 1) ? 0 : 12;
            for (int i = 0; i < TICKS_PER_PHASE; i++) begin
                // ask the receiver for a long hold-off and keep offering
                if ((ph == 2 || ph == 5) && i == 30)
                    squeeze_req = 1'b1;
                offer_tick(rand_tick());
            end
        end
        settle();

        $display("Checked %0d brake commands over %0d register settings (%0d writes).",
                 board.checked, settings, reg_writes);
        $display("Modes seen: %0d stopped, %0d low-speed, %0d regulated; %0d long stalls.",
                 board.mode_hits[MODE_STOP], board.mode_hits[MODE_LOW],
                 board.mode_hits[MODE_REG], squeezes);
        if (board.errors == 0)
            $display("[abs_slip_pd_brake_regulator_core] OK");
        else
            $display("[abs_slip_pd_brake_regulator_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/abspd_pkg.sv
rtl/abspd_in_if.sv
rtl/abspd_out_if.sv
rtl/abs_slip_pd_brake_regulator_core.sv
tb/abs_slip_pd_brake_regulator_core_tb.sv
